[src/tgd_pkg.sv]
package tgd_pkg;

   localparam int RateWidth    = 16;
   localparam int AxisWidth    = (RateWidth + 1 > 17) ? RateWidth + 1 : 17;
   localparam int TimeWidth    = 32;
   localparam int LevelWidth   = 15;
   localparam int MsWidth      = 16;
   localparam int OrientWidth  = 3;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      FuncSample    = 2'd0,
      FuncWake      = 2'd1,
      FuncSleep     = 2'd2,
      FuncReadClear = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      RegRateThreshold = 3'd0,
      RegNeutralRate   = 3'd1,
      RegCooldown      = 3'd2,
      RegSettle        = 3'd3,
      RegPollInterval  = 3'd4,
      RegOrientation   = 3'd5,
      RegInvert        = 3'd6,
      RegPageEnable    = 3'd7
   } reg_index_type;

   localparam logic [OrientWidth-1:0] OrientPortrait     = 3'd0;
   localparam logic [OrientWidth-1:0] OrientInverted     = 3'd1;
   localparam logic [OrientWidth-1:0] OrientLandscapeCw  = 3'd2;
   localparam logic [OrientWidth-1:0] OrientLandscapeCcw = 3'd3;

   localparam logic [LevelWidth-1:0]  RateThresholdReset = 15'd1600;
   localparam logic [LevelWidth-1:0]  NeutralRateReset   = 15'd480;
   localparam logic [MsWidth-1:0]     CooldownReset      = 16'd500;
   localparam logic [MsWidth-1:0]     SettleReset        = 16'd100;
   localparam logic [MsWidth-1:0]     PollIntervalReset  = 16'd50;
   localparam logic [OrientWidth-1:0] OrientationReset   = OrientPortrait;

   typedef struct packed {
      func_type                     func;
      logic signed [RateWidth-1:0]  rate_x;
      logic signed [RateWidth-1:0]  rate_y;
      logic [TimeWidth-1:0]         now_ms;
   } req_type;

   typedef struct packed {
      logic forward_event;
      logic back_event;
      logic activity;
      logic sample_used;
   } rsp_type;

   typedef struct packed {
      logic [LevelWidth-1:0]  rate_threshold;
      logic [LevelWidth-1:0]  neutral_rate;
      logic [MsWidth-1:0]     rearm_ms;
      logic [MsWidth-1:0]     settle_ms;
      logic [MsWidth-1:0]     sample_gap_ms;
      logic [OrientWidth-1:0] orientation;
      logic                   invert_direction;
      logic                   page_enable;
   } cfg_type;

endpackage

[src/tgd_csr.sv]
module tgd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tgd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [tgd_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [tgd_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output tgd_pkg::cfg_type                   cfg
);
   import tgd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            RegRateThreshold: cfg_in.rate_threshold   = csr_pwdata[LevelWidth-1:0];
            RegNeutralRate:   cfg_in.neutral_rate     = csr_pwdata[LevelWidth-1:0];
            RegCooldown:      cfg_in.rearm_ms         = csr_pwdata[MsWidth-1:0];
            RegSettle:        cfg_in.settle_ms        = csr_pwdata[MsWidth-1:0];
            RegPollInterval:  cfg_in.sample_gap_ms    = csr_pwdata[MsWidth-1:0];
            RegOrientation:   cfg_in.orientation      = csr_pwdata[OrientWidth-1:0];
            RegInvert:        cfg_in.invert_direction = csr_pwdata[0];
            RegPageEnable:    cfg_in.page_enable      = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_threshold   <= RateThresholdReset;
         cfg_ff.neutral_rate     <= NeutralRateReset;
         cfg_ff.rearm_ms         <= CooldownReset;
         cfg_ff.settle_ms        <= SettleReset;
         cfg_ff.sample_gap_ms    <= PollIntervalReset;
         cfg_ff.orientation      <= OrientationReset;
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.page_enable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         RegRateThreshold: csr_prdata = CsrDataWidth'(cfg_ff.rate_threshold);
         RegNeutralRate:   csr_prdata = CsrDataWidth'(cfg_ff.neutral_rate);
         RegCooldown:      csr_prdata = CsrDataWidth'(cfg_ff.rearm_ms);
         RegSettle:        csr_prdata = CsrDataWidth'(cfg_ff.settle_ms);
         RegPollInterval:  csr_prdata = CsrDataWidth'(cfg_ff.sample_gap_ms);
         RegOrientation:   csr_prdata = CsrDataWidth'(cfg_ff.orientation);
         RegInvert:        csr_prdata = CsrDataWidth'(cfg_ff.invert_direction);
         RegPageEnable:    csr_prdata = CsrDataWidth'(cfg_ff.page_enable);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

[src/tilt_gesture_detector_core.sv]
// Tilt gesture detector core.
// Request channel (req_valid/req_ready/req_data): one command per request,
// either a gyro sample, wake, sleep or read-and-clear of the event latches.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, in order, carrying the forward, back and activity latches as they
// stand after the request's update and before any clear, plus sample_used.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while no response waits or rsp_ready is
// high; all state is updated in the accept cycle by a single
// compare-and-subtract stage in front of the response register.
// Stall: while a response waits, a new request is taken in the same cycle
// the waiting one is taken; otherwise req_ready stays low.
// Reset: synchronous, active high; the block comes up asleep, latches and
// timestamps cleared, configuration at its defaults.
// Configuration: APB-style port, register i at byte address 4*i, pready
// always high; write only while no request is in flight.
module tilt_gesture_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tgd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tgd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tgd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [tgd_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [tgd_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import tgd_pkg::*;

   cfg_type cfg;

   logic                 awake_ff, awake_in;
   logic                 holding_ff, holding_in;
   logic [TimeWidth-1:0] last_trigger_ff, last_trigger_in;
   logic [TimeWidth-1:0] last_poll_ff, last_poll_in;
   logic [TimeWidth-1:0] wake_ff, wake_in;
   logic                 forward_ff, forward_in;
   logic                 back_ff, back_in;
   logic                 activity_ff, activity_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic signed [AxisWidth-1:0] ext_x, ext_y, axis, threshold;
   logic [AxisWidth-1:0]        abs_rate;
   logic [TimeWidth-1:0]        since_wake, since_poll, since_trigger;
   logic                        sample_ok;
   logic                        fwd_upd, back_upd, act_upd;

   tgd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ext_x     = AxisWidth'(req_data.rate_x);
   assign ext_y     = AxisWidth'(req_data.rate_y);
   assign threshold = $signed(AxisWidth'(cfg.rate_threshold));

   always_comb begin
      unique case (cfg.orientation)
         OrientPortrait:     axis = cfg.invert_direction ? -ext_x : ext_x;
         OrientInverted:     axis = cfg.invert_direction ? ext_x : -ext_x;
         OrientLandscapeCw:  axis = cfg.invert_direction ? ext_y : -ext_y;
         OrientLandscapeCcw: axis = cfg.invert_direction ? -ext_y : ext_y;
         default:            axis = ext_x;
      endcase
   end

   assign abs_rate      = axis[AxisWidth-1] ? unsigned'(-axis) : unsigned'(axis);
   assign since_wake    = req_data.now_ms - wake_ff;
   assign since_poll    = req_data.now_ms - last_poll_ff;
   assign since_trigger = req_data.now_ms - last_trigger_ff;
   assign sample_ok     = awake_ff
                          && (since_wake >= TimeWidth'(cfg.settle_ms))
                          && (since_poll >= TimeWidth'(cfg.sample_gap_ms));

   always_comb begin
      awake_in        = awake_ff;
      holding_in      = holding_ff;
      last_trigger_in = last_trigger_ff;
      last_poll_in    = last_poll_ff;
      wake_in         = wake_ff;
      fwd_upd         = forward_ff;
      back_upd        = back_ff;
      act_upd         = activity_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         unique case (req_data.func)
            FuncSample: begin
               if (sample_ok) begin
                  last_poll_in = req_data.now_ms;
                  if (cfg.page_enable) begin
                     if (holding_ff) begin
                        if (abs_rate < AxisWidth'(cfg.neutral_rate)) begin
                           holding_in = 1'b0;
                        end
                     end else if (since_trigger >= TimeWidth'(cfg.rearm_ms)) begin
                        if (axis > threshold) begin
                           fwd_upd         = 1'b1;
                           act_upd         = 1'b1;
                           holding_in      = 1'b1;
                           last_trigger_in = req_data.now_ms;
                        end else if (axis < -threshold) begin
                           back_upd        = 1'b1;
                           act_upd         = 1'b1;
                           holding_in      = 1'b1;
                           last_trigger_in = req_data.now_ms;
                        end
                     end
                  end
               end
            end
            FuncWake: begin
               last_poll_in    = req_data.now_ms;
               last_trigger_in = req_data.now_ms;
               wake_in         = req_data.now_ms;
               awake_in        = 1'b1;
            end
            FuncSleep: begin
               holding_in = 1'b0;
               awake_in   = 1'b0;
            end
            FuncReadClear: begin
               awake_in = awake_ff;
            end
            default: begin
               awake_in = awake_ff;
            end
         endcase

         rsp_valid_in              = 1'b1;
         rsp_data_in.forward_event = fwd_upd;
         rsp_data_in.back_event    = back_upd;
         rsp_data_in.activity      = act_upd;
         rsp_data_in.sample_used   = (req_data.func == FuncSample) && sample_ok;
      end

      forward_in  = fwd_upd;
      back_in     = back_upd;
      activity_in = act_upd;
      if (req_fire && (req_data.func == FuncSleep || req_data.func == FuncReadClear)) begin
         forward_in  = 1'b0;
         back_in     = 1'b0;
         activity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awake_ff        <= 1'b0;
         holding_ff      <= 1'b0;
         last_trigger_ff <= '0;
         last_poll_ff    <= '0;
         wake_ff         <= '0;
         forward_ff      <= 1'b0;
         back_ff         <= 1'b0;
         activity_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         awake_ff        <= awake_in;
         holding_ff      <= holding_in;
         last_trigger_ff <= last_trigger_in;
         last_poll_ff    <= last_poll_in;
         wake_ff         <= wake_in;
         forward_ff      <= forward_in;
         back_ff         <= back_in;
         activity_ff     <= activity_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_holding_needs_awake: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> awake_ff)
      else $error("gesture held while asleep");

   a_event_sets_activity: assert property (@(posedge clock) disable iff (reset)
      (forward_ff || back_ff) |-> activity_ff)
      else $error("event latch without activity latch");

   a_sleep_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.func == FuncSleep)
      |=> (!awake_ff && !holding_ff && !forward_ff && !back_ff && !activity_ff))
      else $error("sleep left state behind");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_used_only_sample: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.func != FuncSample) |=> !rsp_data_ff.sample_used)
      else $error("command flagged as used sample");

endmodule
